[rtl/mtds_pkg.sv]
// Shared types and constants for the motion triggered door sequencer.
// Phase codes, register indexes, reset values and the state and config bundles.
// No dependencies.
`default_nettype none

package mtds_pkg;

   localparam int TIMER_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [3:0] {
      PH_OFF      = 4'd0,
      PH_ARMED    = 4'd1,
      PH_BEEP_ON  = 4'd2,
      PH_BEEP_OFF = 4'd3,
      PH_CLOSE    = 4'd4,
      PH_WAIT     = 4'd5,
      PH_OPEN     = 4'd6,
      PH_CHIRP    = 4'd7,
      PH_SETTLE   = 4'd8
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COOLDOWN    = 3'd0,
      CSR_MOTOR_PULSE = 3'd1,
      CSR_BEEP_HALF   = 3'd2,
      CSR_CHIRP       = 3'd3,
      CSR_SETTLE      = 3'd4
   } csr_index_type;

   localparam logic [TIMER_W-1:0] COOLDOWN_RESET    = 16'd8000;
   localparam logic [TIMER_W-1:0] MOTOR_PULSE_RESET = 16'd350;
   localparam logic [TIMER_W-1:0] BEEP_HALF_RESET   = 16'd500;
   localparam logic [TIMER_W-1:0] CHIRP_RESET       = 16'd100;
   localparam logic [TIMER_W-1:0] SETTLE_RESET      = 16'd1000;

   typedef struct packed {
      logic [TIMER_W-1:0] cooldown_ms;
      logic [TIMER_W-1:0] motor_pulse_ms;
      logic [TIMER_W-1:0] beep_half_ms;
      logic [TIMER_W-1:0] chirp_ms;
      logic [TIMER_W-1:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [TIMER_W-1:0] phase_timer;
      logic [TIMER_W-1:0] cooldown_timer;
   } state_type;

   typedef struct packed {
      logic motor_close;
      logic motor_enable;
      logic buzzer;
      logic yellow_led;
      logic red_led;
      logic on_led;
      logic green_led;
   } lamps_type;

endpackage

`default_nettype wire

[rtl/mtds_step.sv]
// Next-state and output decode for one tick item of the door sequencer.
// Purely combinational; uses mtds_pkg.
`default_nettype none

module mtds_step
   import mtds_pkg::*;
(
   input  state_type cur,
   input  cfg_type   cfg,
   input  logic      tick,
   input  logic      pir_level,
   input  logic      button_press,
   output state_type nxt,
   output lamps_type lamps
);

   logic               expired;
   logic [TIMER_W-1:0] timer_dec;
   logic [TIMER_W-1:0] cool_cur;

   always_comb begin
      expired   = tick && (cur.phase_timer <= TIMER_W'(1));
      timer_dec = tick ? (expired ? '0 : cur.phase_timer - TIMER_W'(1)) : cur.phase_timer;
      cool_cur  = cur.cooldown_timer;
      if ((cur.phase == PH_CLOSE || cur.phase == PH_WAIT) && tick && cool_cur != '0) begin
         cool_cur = cool_cur - TIMER_W'(1);
      end

      nxt.phase          = cur.phase;
      nxt.phase_timer    = cur.phase_timer;
      nxt.cooldown_timer = cool_cur;

      case (cur.phase)
         PH_OFF: begin
            if (button_press) begin
               nxt.phase       = PH_ARMED;
               nxt.phase_timer = '0;
            end
         end
         PH_ARMED: begin
            if (button_press) begin
               nxt.phase       = PH_OFF;
               nxt.phase_timer = '0;
            end else if (pir_level) begin
               nxt.phase       = PH_BEEP_ON;
               nxt.phase_timer = cfg.beep_half_ms;
            end
         end
         PH_BEEP_ON: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               nxt.phase       = PH_BEEP_OFF;
               nxt.phase_timer = cfg.beep_half_ms;
            end
         end
         PH_BEEP_OFF: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               if (pir_level) begin
                  nxt.phase       = PH_BEEP_ON;
                  nxt.phase_timer = cfg.beep_half_ms;
               end else begin
                  nxt.phase          = PH_CLOSE;
                  nxt.phase_timer    = cfg.motor_pulse_ms;
                  nxt.cooldown_timer = cfg.cooldown_ms;
               end
            end
         end
         PH_CLOSE: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               if (cool_cur == '0) begin
                  nxt.phase       = PH_OPEN;
                  nxt.phase_timer = cfg.motor_pulse_ms;
               end else begin
                  nxt.phase       = PH_WAIT;
                  nxt.phase_timer = '0;
               end
            end
         end
         PH_WAIT: begin
            if (cool_cur == '0) begin
               nxt.phase       = PH_OPEN;
               nxt.phase_timer = cfg.motor_pulse_ms;
            end
         end
         PH_OPEN: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               nxt.phase       = PH_CHIRP;
               nxt.phase_timer = cfg.chirp_ms;
            end
         end
         PH_CHIRP: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               if (cfg.settle_ms == '0) begin
                  nxt.phase       = PH_ARMED;
                  nxt.phase_timer = '0;
               end else begin
                  nxt.phase       = PH_SETTLE;
                  nxt.phase_timer = cfg.settle_ms;
               end
            end
         end
         PH_SETTLE: begin
            nxt.phase_timer = timer_dec;
            if (expired) begin
               nxt.phase       = PH_ARMED;
               nxt.phase_timer = '0;
            end
         end
         default: begin
            nxt.phase       = PH_OFF;
            nxt.phase_timer = '0;
         end
      endcase

      lamps.green_led    = (nxt.phase == PH_OFF);
      lamps.on_led       = (nxt.phase != PH_OFF);
      lamps.red_led      = (nxt.phase == PH_BEEP_ON || nxt.phase == PH_BEEP_OFF);
      lamps.yellow_led   = (nxt.phase == PH_CLOSE || nxt.phase == PH_WAIT
                            || nxt.phase == PH_OPEN);
      lamps.buzzer       = (nxt.phase == PH_BEEP_ON || nxt.phase == PH_CHIRP);
      lamps.motor_enable = (nxt.phase == PH_CLOSE || nxt.phase == PH_OPEN);
      lamps.motor_close  = (nxt.phase == PH_CLOSE);
   end

endmodule

`default_nettype wire

[rtl/motion_triggered_door_sequencer.sv]
// Top level of the motion triggered door sequencer: stream ports, timing registers,
// sequencer state and the registered result stage. Uses mtds_pkg and mtds_step.
//
// Each request is one sample (tick, motion level, button press) and yields exactly one
// response carrying the LED, buzzer and motor drive levels after that sample. One request
// is taken every clock; the response sits in a single output register that is refilled
// in the same cycle it is taken, so the only stall source is a held-off rsp_tready.
// The response becomes valid in the cycle after the request transfer. Timing registers are
// written through the csr port, which is always ready; new values take effect the next
// time the corresponding phase starts.
`default_nettype none

module motion_triggered_door_sequencer
   import mtds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] tick, [1] pir_level, [2] button_press, [7:3] zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] green_led, [1] on_led, [2] red_led, [3] yellow_led, [4] buzzer,
   // [5] motor_enable, [6] motor_close, [7] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIMER_W-1:0]     csr_data
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   lamps_type lamps_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   lamps_type rsp_lamps_ff;
   logic      req_xfer;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   mtds_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .tick         (req_tdata[0]),
      .pir_level    (req_tdata[1]),
      .button_press (req_tdata[2]),
      .nxt          (state_in),
      .lamps        (lamps_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_ms    <= COOLDOWN_RESET;
         cfg_ff.motor_pulse_ms <= MOTOR_PULSE_RESET;
         cfg_ff.beep_half_ms   <= BEEP_HALF_RESET;
         cfg_ff.chirp_ms       <= CHIRP_RESET;
         cfg_ff.settle_ms      <= SETTLE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COOLDOWN:    cfg_ff.cooldown_ms    <= csr_data;
            CSR_MOTOR_PULSE: cfg_ff.motor_pulse_ms <= csr_data;
            CSR_BEEP_HALF:   cfg_ff.beep_half_ms   <= csr_data;
            CSR_CHIRP:       cfg_ff.chirp_ms       <= csr_data;
            CSR_SETTLE:      cfg_ff.settle_ms      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_OFF;
         state_ff.phase_timer    <= '0;
         state_ff.cooldown_timer <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_lamps_ff <= lamps_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_lamps_ff};

endmodule

`default_nettype wire

[rtl/mtds_checker.sv]
// Port-level checks for motion_triggered_door_sequencer, bound to the top level.
// Uses mtds_pkg widths only.
`default_nettype none

module mtds_checker
   import mtds_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("request transfer gave no response");

   a_led_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] != rsp_tdata[1]) && !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("indicator levels inconsistent");

   a_motor_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[5] && rsp_tdata[3])
      else $error("close direction without motor drive");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind motion_triggered_door_sequencer mtds_checker u_mtds_checker (.*);

`default_nettype wire
